// ----- hdl/convex_polygon_point_test_macros.svh -----
// Assertion macros shared by the polygon test RTL.
`ifndef CONVEX_POLYGON_POINT_TEST_MACROS_SVH
`define CONVEX_POLYGON_POINT_TEST_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define CPPT_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("convex_polygon_point_test: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define CPPT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("convex_polygon_point_test: next-cycle check failed");

`endif

// ----- hdl/cppt_pkg.sv -----
// Constants and types shared by the polygon test block.
`default_nettype none

package cppt_pkg;

   localparam int MAX_VERTICES = 8;
   localparam int MIN_VERTICES = 3;

   localparam int COORD_W = 12;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int CROSS_W = PROD_W + 1;
   localparam int VTX_W   = 2 * COORD_W;

   localparam int SLOT_W = 3;
   localparam int IDX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int VC_W   = 4;
   localparam int CMP_W  = (CNT_W > VC_W) ? CNT_W : VC_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEST = 1'b1;

   localparam logic [0:0] REG_VERTEX_COUNT = 1'b0;

   // Tag carried alongside one edge through the datapath.
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } cppt_tag_type;

   // Verdict of one test point.
   typedef struct packed {
      logic vld;
      logic hit;
   } cppt_result_type;

endpackage

`default_nettype wire

// ----- hdl/cppt_edge_unit.sv -----
// Edge datapath: differences, cross product, sign check and verdict.
`default_nettype none

module cppt_edge_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cppt_pkg::cppt_tag_type               edge_tag,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  a_x,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  a_y,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  b_x,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  b_y,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  p_x,
   input  wire logic signed [cppt_pkg::COORD_W-1:0]  p_y,
   output cppt_pkg::cppt_result_type                 result
);

   cppt_pkg::cppt_tag_type d_tag_ff, m_tag_ff;
   logic signed [cppt_pkg::DIFF_W-1:0]  ex_ff, ey_ff, dx_ff, dy_ff;
   logic signed [cppt_pkg::PROD_W-1:0]  p1_ff, p2_ff;
   logic signed [cppt_pkg::CROSS_W-1:0] cross_sum;
   logic nonneg;
   logic first_nonneg_ff, first_nonneg_in;
   logic ok_ff, ok_in;
   cppt_pkg::cppt_result_type result_ff, result_in;

   // Stage D: edge vector and point offset.
   always_ff @(posedge clock) begin
      ex_ff <= cppt_pkg::DIFF_W'(b_x) - cppt_pkg::DIFF_W'(a_x);
      ey_ff <= cppt_pkg::DIFF_W'(b_y) - cppt_pkg::DIFF_W'(a_y);
      dx_ff <= cppt_pkg::DIFF_W'(p_x) - cppt_pkg::DIFF_W'(a_x);
      dy_ff <= cppt_pkg::DIFF_W'(p_y) - cppt_pkg::DIFF_W'(a_y);
      // Stage M: the two partial products.
      p1_ff <= cppt_pkg::PROD_W'(ex_ff) * cppt_pkg::PROD_W'(dy_ff);
      p2_ff <= cppt_pkg::PROD_W'(ey_ff) * cppt_pkg::PROD_W'(dx_ff);
   end

   assign cross_sum = cppt_pkg::CROSS_W'(p1_ff) - cppt_pkg::CROSS_W'(p2_ff);
   assign nonneg    = ~cross_sum[cppt_pkg::CROSS_W-1];

   // Stage S: latch the first edge's sign, clear ok on any mismatch.
   always_comb begin
      first_nonneg_in = first_nonneg_ff;
      ok_in           = ok_ff;
      result_in       = '0;
      if (m_tag_ff.vld) begin
         if (m_tag_ff.first) begin
            first_nonneg_in = nonneg;
            ok_in           = 1'b1;
         end else begin
            ok_in = ok_ff & (nonneg == first_nonneg_ff);
         end
         if (m_tag_ff.last) begin
            result_in.vld = 1'b1;
            result_in.hit = ok_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_tag_ff  <= '0;
         m_tag_ff  <= '0;
         result_ff <= '0;
         ok_ff     <= 1'b0;
      end else begin
         d_tag_ff  <= edge_tag;
         m_tag_ff  <= d_tag_ff;
         result_ff <= result_in;
         ok_ff     <= ok_in;
      end
      first_nonneg_ff <= first_nonneg_in;
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ----- hdl/convex_polygon_point_test.sv -----
// Top level of the convex polygon point test: vertex memory, edge sequencer, registers.
//
// Usage:
//  - req channel: one beat is a load (tuser = 0) or a test (tuser = 1).
//    A load writes vertex (x, y) into slot vertex_index; loads may follow each
//    other every cycle while no test is in flight.
//  - A test walks the edges 0->1, 1->2, ..., (n-1)->0 of the first n vertices,
//    n = vertex_count clamped to 3..8, reading one vertex per cycle from the
//    vertex memory. One edge enters the cross-product pipeline per cycle.
//  - rsp channel: one beat per test, tdata[0] = 1 when the point is inside.
//    A test holds off further items until its verdict is in the output
//    register and the block is idle again, so tests do not overlap.
//  - csr port: register 0 at address 0 holds vertex_count (reset 3). Write
//    it only while no test is in flight.
//  - When the receiver stalls, the verdict holds in the output register;
//    loads are still taken, and a new test waits until the verdict leaves.
//  - Synchronous reset clears control state and sets vertex_count to 3; the
//    vertex memory is not cleared and must be loaded before use.
`default_nettype none
`include "convex_polygon_point_test_macros.svh"

module convex_polygon_point_test (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata fields, low bit up: vertex_index[2:0], coord_x[14:3],
   // coord_y[26:15], zero pad [31:27]
   input  wire logic [31:0] req_tdata,
   // req_tuser fields: opcode[0]
   input  wire logic        req_tuser,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rsp_tdata fields, low bit up: inside_res[0], zero pad [7:1]
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // Unpack the request beat.
   logic                                  op;
   logic [cppt_pkg::SLOT_W-1:0]           slot;
   logic signed [cppt_pkg::COORD_W-1:0]   cx, cy;

   assign op   = req_tuser;
   assign slot = req_tdata[cppt_pkg::SLOT_W-1:0];
   assign cx   = req_tdata[cppt_pkg::SLOT_W +: cppt_pkg::COORD_W];
   assign cy   = req_tdata[cppt_pkg::SLOT_W + cppt_pkg::COORD_W +: cppt_pkg::COORD_W];

   // Configuration register.
   logic [cppt_pkg::VC_W-1:0] vertex_count_ff;
   logic                      csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= cppt_pkg::VC_W'(cppt_pkg::MIN_VERTICES);
      end else if (csr_wr && csr_paddr[2] == cppt_pkg::REG_VERTEX_COUNT) begin
         vertex_count_ff <= csr_pwdata[cppt_pkg::VC_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == cppt_pkg::REG_VERTEX_COUNT) begin
         csr_prdata = 32'(vertex_count_ff);
      end
   end

   // Output register; a test is taken only when it is free or draining.
   logic rsp_valid_ff, rsp_valid_in;
   logic inside_ff, inside_in;
   logic req_acc, test_acc, load_acc;

   assign req_tready = (state_ff == ST_IDLE) &&
                       (op == cppt_pkg::OP_LOAD || !rsp_valid_ff || rsp_tready);
   assign req_acc    = req_tvalid & req_tready;
   assign test_acc   = req_acc & (op == cppt_pkg::OP_TEST);
   assign load_acc   = req_acc & (op == cppt_pkg::OP_LOAD);

   // Clamp the vertex count at test start.
   logic [cppt_pkg::CMP_W-1:0] vc_ext;
   logic [cppt_pkg::CNT_W-1:0] n_clamp;
   logic [cppt_pkg::CNT_W-1:0] n_ff;
   logic signed [cppt_pkg::COORD_W-1:0] px_ff, py_ff;

   assign vc_ext = cppt_pkg::CMP_W'(vertex_count_ff);

   always_comb begin
      if (vc_ext < cppt_pkg::CMP_W'(cppt_pkg::MIN_VERTICES)) begin
         n_clamp = cppt_pkg::CNT_W'(cppt_pkg::MIN_VERTICES);
      end else if (vc_ext > cppt_pkg::CMP_W'(cppt_pkg::MAX_VERTICES)) begin
         n_clamp = cppt_pkg::CNT_W'(cppt_pkg::MAX_VERTICES);
      end else begin
         n_clamp = vc_ext[cppt_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (test_acc) begin
         n_ff  <= n_clamp;
         px_ff <= cx;
         py_ff <= cy;
      end
   end

   // Sequencer: read slots 0..n-1, then slot 0 again for the closing edge.
   logic [cppt_pkg::CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic                       rd_en;
   logic [cppt_pkg::IDX_W-1:0] rd_addr;
   logic                       rd_closing;
   cppt_pkg::cppt_tag_type     rd_tag_in, rd_tag_ff;

   assign rd_en      = (state_ff == ST_RUN);
   assign rd_closing = (rd_cnt_ff == n_ff);
   assign rd_addr    = rd_closing ? '0 : rd_cnt_ff[cppt_pkg::IDX_W-1:0];

   cppt_pkg::cppt_result_type edge_res;

   always_comb begin
      state_in  = state_ff;
      rd_cnt_in = rd_cnt_ff;
      rd_tag_in = '0;
      case (state_ff)
         ST_IDLE: begin
            rd_cnt_in = '0;
            if (test_acc) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // Every read after the first closes an edge with the one before it.
            rd_tag_in.vld   = (rd_cnt_ff != '0);
            rd_tag_in.first = (rd_cnt_ff == cppt_pkg::CNT_W'(1));
            rd_tag_in.last  = rd_closing;
            rd_cnt_in       = rd_cnt_ff + cppt_pkg::CNT_W'(1);
            if (rd_closing) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (edge_res.vld) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_cnt_ff <= '0;
         rd_tag_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         rd_tag_ff <= rd_tag_in;
      end
   end

   // Vertex memory: {y, x} per slot, one write and one registered read port.
   logic [cppt_pkg::VTX_W-1:0] vtx_mem [cppt_pkg::MAX_VERTICES];
   logic [cppt_pkg::VTX_W-1:0] rd_data_ff;
   logic [cppt_pkg::VTX_W-1:0] prev_ff;
   logic                       wr_ok;

   assign wr_ok = (int'(slot) < cppt_pkg::MAX_VERTICES);

   always_ff @(posedge clock) begin
      if (load_acc && wr_ok) begin
         vtx_mem[cppt_pkg::IDX_W'(slot)] <= {cy, cx};
      end
      if (rd_en) begin
         rd_data_ff <= vtx_mem[rd_addr];
         // Hold the previous vertex as the start of the next edge.
         prev_ff    <= rd_data_ff;
      end
   end

   cppt_edge_unit u_edge (
      .clock    (clock),
      .reset    (reset),
      .edge_tag (rd_tag_ff),
      .a_x      (prev_ff[cppt_pkg::COORD_W-1:0]),
      .a_y      (prev_ff[cppt_pkg::VTX_W-1:cppt_pkg::COORD_W]),
      .b_x      (rd_data_ff[cppt_pkg::COORD_W-1:0]),
      .b_y      (rd_data_ff[cppt_pkg::VTX_W-1:cppt_pkg::COORD_W]),
      .p_x      (px_ff),
      .p_y      (py_ff),
      .result   (edge_res)
   );

   // Load the verdict into the output register, drop it once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      inside_in    = inside_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (edge_res.vld) begin
         rsp_valid_in = 1'b1;
         inside_in    = edge_res.hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      inside_ff <= inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, inside_ff};

   `CPPT_ASSERT_IMPL(a_result_in_wait, edge_res.vld, state_ff == ST_WAIT)
   `CPPT_ASSERT_IMPL(a_read_in_range, state_ff == ST_RUN, rd_cnt_ff <= n_ff)
   `CPPT_ASSERT_NEXT(a_result_lands, edge_res.vld, rsp_valid_ff)

endmodule

`default_nettype wire

// ----- sim/convex_polygon_point_test_tb.sv -----
// Self-checking testbench for the convex polygon point test block.
`timescale 1ns / 100ps

module convex_polygon_point_test_tb;

   // Cycles without any accepted beat before the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Pause after the last verdict before touching the register (two worst-case tests).
   localparam int SETTLE_CYCLES = 2 * (cppt_pkg::MAX_VERTICES + 6);
   // Idle percentage on each side, and the window with no idling at all.
   localparam int IDLE_PCT = 6;
   localparam int QUIET_FROM = 4000;
   localparam int QUIET_TO = 7000;
   localparam int PHASE_ITEMS = 290;

   typedef enum {ROW_LOAD, ROW_TEST, ROW_CFG} row_kind_type;

   // One line of the directed stimulus table.
   typedef struct {
      row_kind_type                        kind;
      logic [cppt_pkg::SLOT_W-1:0]         slot;
      logic signed [cppt_pkg::COORD_W-1:0] x;
      logic signed [cppt_pkg::COORD_W-1:0] y;
      logic                                typed;   // verdict typed in below
      logic                                want;
      logic [cppt_pkg::VC_W-1:0]           count;   // register value for a ROW_CFG line
   } dir_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow copy of the vertex memory and the register, as the block should hold them.
   logic signed [cppt_pkg::COORD_W-1:0] vtx_x [cppt_pkg::MAX_VERTICES];
   logic signed [cppt_pkg::COORD_W-1:0] vtx_y [cppt_pkg::MAX_VERTICES];
   logic [cppt_pkg::VC_W-1:0] vc_shadow = cppt_pkg::VC_W'(cppt_pkg::MIN_VERTICES);

   // Verdicts predicted for accepted tests, oldest first.
   logic pending_verdicts [$];

   dir_row_type dir_tab [$];

   int  cycle_no = 0;
   int  error_count = 0;
   int  idle_run = 0;
   int  loads_sent = 0;
   int  tests_checked = 0;
   int  settings_used = 0;
   logic quiet;

   // Octagon directions; any subset taken in order stays convex.
   int dir_x [8] = '{100, 71, 0, -71, -100, -71, 0, 71};
   int dir_y [8] = '{0, 71, 100, 71, 0, -71, -100, -71};

   convex_polygon_point_test i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

   // Number of vertices a test walks: the register clamped to the table.
   function automatic int poly_size();
      if (vc_shadow < cppt_pkg::MIN_VERTICES) return cppt_pkg::MIN_VERTICES;
      if (vc_shadow > cppt_pkg::MAX_VERTICES) return cppt_pkg::MAX_VERTICES;
      return int'(vc_shadow);
   endfunction

   // Edge-sign test of one point against the shadow polygon; zero counts as positive.
   function automatic logic point_inside(input logic signed [cppt_pkg::COORD_W-1:0] px,
                                         input logic signed [cppt_pkg::COORD_W-1:0] py);
      logic signed [cppt_pkg::CROSS_W-1:0] ex, ey, dx, dy, cross_val;
      logic first_nonneg, nonneg, agree;
      int n, j;
      n = poly_size();
      agree = 1'b1;
      first_nonneg = 1'b1;
      for (int i = 0; i < n; i++) begin
         j = (i + 1 < n) ? i + 1 : 0;
         ex = vtx_x[j] - vtx_x[i];
         ey = vtx_y[j] - vtx_y[i];
         dx = px - vtx_x[i];
         dy = py - vtx_y[i];
         cross_val = ex * dy - ey * dx;
         nonneg = ~cross_val[cppt_pkg::CROSS_W-1];
         if (i == 0) first_nonneg = nonneg;
         if (nonneg != first_nonneg) agree = 1'b0;
      end
      return agree;
   endfunction

   // Present one req beat and hold it until taken; update the shadow state on acceptance.
   task automatic send_item(input logic op, input logic [cppt_pkg::SLOT_W-1:0] slot,
                            input logic signed [cppt_pkg::COORD_W-1:0] x,
                            input logic signed [cppt_pkg::COORD_W-1:0] y,
                            input logic typed, input logic want);
      // Drop valid now and then so gaps land on every phase of a test.
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, y, x, slot};
      do @(posedge clock); while (!req_tready);
      if (op == cppt_pkg::OP_LOAD) begin
         vtx_x[slot] = x;
         vtx_y[slot] = y;
         loads_sent++;
      end else begin
         pending_verdicts.insert(pending_verdicts.size(),
                                 typed ? want : point_inside(x, y));
      end
   endtask

   // Stop sending, wait for every verdict, then let the pipeline settle.
   task automatic drain_verdicts();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of vertex_count followed by a read back of the same register.
   task automatic write_vertex_count(input logic [cppt_pkg::VC_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {cppt_pkg::REG_VERTEX_COUNT, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      vc_shadow = value;
      settings_used++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[cppt_pkg::VC_W-1:0] !== value) begin
         $error("vertex_count: expected %0d, got %0d", value,
                csr_prdata[cppt_pkg::VC_W-1:0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic add_row(input row_kind_type kind, input int slot, input int x, input int y,
                          input logic typed, input logic want, input int count);
      dir_row_type r;
      r.kind  = kind;
      r.slot  = cppt_pkg::SLOT_W'(slot);
      r.x     = cppt_pkg::COORD_W'(x);
      r.y     = cppt_pkg::COORD_W'(y);
      r.typed = typed;
      r.want  = want;
      r.count = cppt_pkg::VC_W'(count);
      dir_tab.insert(dir_tab.size(), r);
   endtask

   // One register setting: mostly convex polygons probed by tests, some raw noise.
   task automatic run_phase(input logic [cppt_pkg::VC_W-1:0] count, input int budget);
      int sent, n, r, lim, cx, cy, k, start, tests, pick, burst;
      int vx [cppt_pkg::MAX_VERTICES];
      int vy [cppt_pkg::MAX_VERTICES];
      int px, py;
      logic [7:0] mask;
      logic cw;
      drain_verdicts();
      write_vertex_count(count);
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 85) begin
            n = poly_size();
            do mask = 8'($urandom_range(255)); while ($countones(mask) != n);
            r   = $urandom_range(18, 1);
            lim = 2047 - 110 * r;
            cx  = int'($urandom_range(2 * lim)) - lim;
            cy  = int'($urandom_range(2 * lim)) - lim;
            k = 0;
            for (int d = 0; d < 8; d++) begin
               if (mask[d]) begin
                  vx[k] = cx + dir_x[d] * r;
                  vy[k] = cy + dir_y[d] * r;
                  k++;
               end
            end
            // Reverse the slot order half the time for a clockwise polygon.
            cw = 1'($urandom_range(1));
            start = $urandom_range(n - 1);
            for (int i = 0; i < n; i++) begin
               k = (start + i) % n;
               send_item(cppt_pkg::OP_LOAD, cppt_pkg::SLOT_W'(cw ? n - 1 - k : k),
                         cppt_pkg::COORD_W'(vx[k]), cppt_pkg::COORD_W'(vy[k]),
                         1'b0, 1'b0);
            end
            tests = $urandom_range(10, 3);
            for (int t = 0; t < tests; t++) begin
               pick = $urandom_range(99);
               k = $urandom_range(n - 1);
               if (pick < 45) begin
                  px = cx + int'($urandom_range(220 * r)) - 110 * r;
                  py = cy + int'($urandom_range(220 * r)) - 110 * r;
               end else if (pick < 65) begin
                  px = vx[k];
                  py = vy[k];
               end else if (pick < 85) begin
                  px = (vx[k] + vx[(k + 1) % n]) / 2;
                  py = (vy[k] + vy[(k + 1) % n]) / 2;
               end else begin
                  px = int'($urandom_range(4095)) - 2048;
                  py = int'($urandom_range(4095)) - 2048;
               end
               send_item(cppt_pkg::OP_TEST, cppt_pkg::SLOT_W'($urandom_range(7)),
                         cppt_pkg::COORD_W'(px), cppt_pkg::COORD_W'(py), 1'b0, 1'b0);
            end
            sent += n + tests;
         end else begin
            // Noise: raw loads and tests anywhere in the coordinate range.
            burst = $urandom_range(4, 1);
            for (int b = 0; b < burst; b++) begin
               send_item(1'($urandom_range(1)), cppt_pkg::SLOT_W'($urandom_range(7)),
                         cppt_pkg::COORD_W'($urandom), cppt_pkg::COORD_W'($urandom),
                         1'b0, 1'b0);
            end
            sent += burst;
         end
      end
   endtask

   // Take verdict beats and compare with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            $error("inside_res: no verdict expected, got %0d", rsp_tdata[0]);
            error_count++;
         end else begin
            if (rsp_tdata[0] !== pending_verdicts[0]) begin
               $error("inside_res: expected %0d, got %0d", pending_verdicts[0], rsp_tdata[0]);
               error_count++;
            end
            void'(pending_verdicts.pop_front());
            tests_checked++;
         end
      end
   end

   // Stall the receiver at random outside the quiet window.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: count cycles in which no beat moves on any port.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_run <= 0;
      end else if (idle_run + 1 >= STALL_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
         $display("convex_polygon_point_test verification failed");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

   initial begin
      // Fill every slot first; the memory is not cleared by reset.
      add_row(ROW_LOAD, 0, -2048, -2048, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 1, 2047, -2048, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 2, 2047, 2047, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 3, -2048, 2047, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 4, -1024, 1536, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 5, 0, 0, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 6, 1, -1, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 7, -2047, -5, 1'b0, 1'b0, 0);
      // Reset count of three: full-range triangle, corners and edges.
      add_row(ROW_TEST, 0, 2047, -2048, 1'b1, 1'b1, 0);
      add_row(ROW_TEST, 7, -2048, 2047, 1'b1, 1'b0, 0);
      add_row(ROW_TEST, 3, 0, -2048, 1'b1, 1'b1, 0);
      add_row(ROW_TEST, 5, -2048, -2048, 1'b1, 1'b1, 0);
      add_row(ROW_TEST, 2, 1000, -1000, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 6, -1, 1, 1'b0, 1'b0, 0);
      // Swap two corners for a clockwise triangle.
      add_row(ROW_LOAD, 1, 2047, 2047, 1'b0, 1'b0, 0);
      add_row(ROW_LOAD, 2, 2047, -2048, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 1, 1000, -1000, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 4, -2000, 2000, 1'b0, 1'b0, 0);
      // Count below the minimum, then above the table size.
      add_row(ROW_CFG, 0, 0, 0, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 0, 1500, -1500, 1'b0, 1'b0, 0);
      add_row(ROW_CFG, 0, 0, 0, 1'b0, 1'b0, 15);
      add_row(ROW_TEST, 7, 0, 0, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 3, -2048, 0, 1'b0, 1'b0, 0);
      add_row(ROW_TEST, 5, 2047, 2047, 1'b0, 1'b0, 0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CFG) begin
            drain_verdicts();
            write_vertex_count(dir_tab[i].count);
         end else begin
            send_item(dir_tab[i].kind == ROW_TEST ? cppt_pkg::OP_TEST : cppt_pkg::OP_LOAD,
                      dir_tab[i].slot, dir_tab[i].x, dir_tab[i].y,
                      dir_tab[i].typed, dir_tab[i].want);
         end
      end

      run_phase(4'd8, PHASE_ITEMS);
      run_phase(4'd15, PHASE_ITEMS);
      run_phase(4'd0, PHASE_ITEMS);
      run_phase(4'd5, PHASE_ITEMS);
      run_phase(4'd3, PHASE_ITEMS);
      run_phase(cppt_pkg::VC_W'($urandom_range(15)), PHASE_ITEMS);

      drain_verdicts();
      if (pending_verdicts.size() != 0) begin
         $error("inside_res: %0d verdicts never arrived", pending_verdicts.size());
         error_count++;
      end

      $display("Covered %0d vertex loads and %0d checked point tests", loads_sent, tests_checked);
      $display("across %0d vertex_count writes, clamped counts from 3 to 8", settings_used);
      if (error_count == 0) begin
         $display("convex_polygon_point_test verification clean");
      end else begin
         $display("convex_polygon_point_test verification failed");
      end
      $finish;
   end

endmodule
